// ===== design/radix_integer_parser_unit_macros.svh =====
`ifndef RADIX_INTEGER_PARSER_UNIT_MACROS_SVH
`define RADIX_INTEGER_PARSER_UNIT_MACROS_SVH

// Plain check, off while in reset.
`define RIP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication to the following cycle, off while in reset.
`define RIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rip_pkg.sv =====
package rip_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int RADIX_BITS    = 6;
  localparam int DIGIT_BITS    = 6;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 2;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE  = 6'd63;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_BITS-1:0] RADIX_BAD   = 6'd1;

  localparam logic REG_RADIX_IDX = 1'b0;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] parsed_value;
    logic                         is_defined;
  } out_item_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  is_space;
    logic                  is_minus;
    logic                  is_x;
    logic                  last;
  } cls_item_t;

endpackage

// ===== design/radix_integer_parser_unit.sv =====
// Streaming string-to-integer converter, one string byte per transfer.
// Input queue side: drive in_item and push; a transfer happens when push is
// high and full is low. last_char marks the final byte of a string.
// Result queue side: while empty is low, out_item holds the oldest result;
// pop takes it. Exactly one result per string, on its last byte.
// Throughput: one byte per cycle while nothing stalls, set by the single
// multiply-add of the digit unit in the back end. The result of a string
// passes the front register, the classified-byte queue and the finish
// register, then is written into the result queue.
// When the result side stalls, only a last byte waits, once the finish register
// and result queue are full; then full rises through the classified-byte queue.
// Radix register at byte address 0 of the APB port, reset value 10;
// write it only while the block is idle.
// Reset (rst_n low, synchronous) empties all queues, sets the radix to 10
// and clears the per-string parse state.
module radix_integer_parser_unit #(
  parameter int MID_DEPTH = rip_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = rip_pkg::OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  rip_pkg::in_item_t                  in_item,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output rip_pkg::out_item_t                 out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rip_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [rip_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [rip_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int CW = $bits(rip_pkg::cls_item_t);
  localparam int OW = $bits(rip_pkg::out_item_t);

  logic [rip_pkg::RADIX_BITS-1:0] radix_r;
  logic                           cfg_wr;

  logic               cls_push, cls_full, cls_pop, cls_empty;
  rip_pkg::cls_item_t cls_in, cls_out;
  logic [CW-1:0]      cls_rdata;

  logic               res_push, res_full;
  rip_pkg::out_item_t res_item;
  logic [OW-1:0]      out_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rip_pkg::REG_RADIX_IDX);
  assign prdata = (paddr[2] == rip_pkg::REG_RADIX_IDX) ?
                  rip_pkg::CFG_DATA_BITS'(radix_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rip_pkg::RADIX_RESET;
    end else if (cfg_wr) begin
      radix_r <= pwdata[rip_pkg::RADIX_BITS-1:0];
    end
  end

  rip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cls_push (cls_push),
    .cls_item (cls_in),
    .cls_full (cls_full)
  );

  rip_fifo #(
    .WIDTH (CW),
    .DEPTH (MID_DEPTH)
  ) u_cls_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cls_push),
    .wdata (cls_in),
    .full  (cls_full),
    .pop   (cls_pop),
    .rdata (cls_rdata),
    .empty (cls_empty)
  );

  assign cls_out = rip_pkg::cls_item_t'(cls_rdata);

  rip_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .radix_setting (radix_r),
    .cls_item      (cls_out),
    .cls_empty     (cls_empty),
    .cls_pop       (cls_pop),
    .res_push      (res_push),
    .res_item      (res_item),
    .res_full      (res_full)
  );

  rip_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_item = rip_pkg::out_item_t'(out_rdata);

endmodule

// ===== design/rip_fifo.sv =====
`include "radix_integer_parser_unit_macros.svh"

module rip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `RIP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "fifo count above depth")
  `RIP_ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "fifo count did not step up")

endmodule

// ===== design/rip_front.sv =====
module rip_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rip_pkg::in_item_t  in_item,
  output logic               full,
  output logic               cls_push,
  output rip_pkg::cls_item_t cls_item,
  input  logic               cls_full
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NBSP  = 8'hA0;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  logic               valid_r, valid_nxt;
  rip_pkg::cls_item_t item_r;
  rip_pkg::cls_item_t cls_nxt;
  logic               accept;
  logic [7:0]         c;

  assign full     = valid_r && cls_full;
  assign accept   = push && !full;
  assign cls_push = valid_r && !cls_full;
  assign cls_item = item_r;
  assign valid_nxt = accept || (valid_r && cls_full);
  assign c        = in_item.char_code;

  always_comb begin
    cls_nxt.last     = in_item.last_char;
    cls_nxt.is_minus = (c == CH_MINUS);
    cls_nxt.is_x     = (c == CH_LX) || (c == CH_UX);
    cls_nxt.is_space = (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) ||
                       (c == CH_CR) || (c == CH_SP) || (c == CH_NBSP);
    if (c >= CH_0 && c <= CH_9) begin
      cls_nxt.digit = rip_pkg::DIGIT_BITS'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      cls_nxt.digit = rip_pkg::DIGIT_BITS'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      cls_nxt.digit = rip_pkg::DIGIT_BITS'(c - CH_UA + 8'd10);
    end else begin
      cls_nxt.digit = rip_pkg::DIGIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= cls_nxt;
    end
  end

endmodule

// ===== design/rip_back.sv =====
`include "radix_integer_parser_unit_macros.svh"

module rip_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [rip_pkg::RADIX_BITS-1:0]       radix_setting,
  input  rip_pkg::cls_item_t                   cls_item,
  input  logic                                 cls_empty,
  output logic                                 cls_pop,
  output logic                                 res_push,
  output rip_pkg::out_item_t                   res_item,
  input  logic                                 res_full
);

  localparam int VB = rip_pkg::VALUE_BITS;
  localparam int RB = rip_pkg::RADIX_BITS;

  localparam logic [1:0] PH_WS     = 2'd0;
  localparam logic [1:0] PH_START  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [VB-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic          seen_r, seen_nxt;
  logic          prefix_r, prefix_nxt;
  logic [RB-1:0] act_radix_r, act_radix_nxt;

  logic          done_v_r, done_v_nxt;
  logic [VB-1:0] fin_acc_r;
  logic          fin_neg_r;
  logic          fin_ok_r;

  logic          done_ready, fire, finish;
  logic          hex_ok, bad, do_start, do_digits, do_take, zero_hex;
  logic [RB-1:0] radix;
  logic [VB-1:0] mac;

  assign done_ready = !done_v_r || !res_full;
  assign fire       = !cls_empty && (!cls_item.last || done_ready);
  assign finish     = fire && cls_item.last;
  assign cls_pop    = fire;

  assign hex_ok = (radix_setting == rip_pkg::RADIX_AUTO) || (radix_setting == rip_pkg::RADIX_HEX);
  assign bad    = (radix_setting == rip_pkg::RADIX_BAD) || (radix_setting > rip_pkg::RADIX_MAX);
  assign radix  = (radix_setting != rip_pkg::RADIX_AUTO) ? radix_setting : act_radix_r;
  assign mac    = acc_r * VB'(radix) + VB'(cls_item.digit);
  assign zero_hex = (cls_item.digit == '0) && hex_ok &&
                    (radix == ((radix_setting == rip_pkg::RADIX_AUTO) ?
                               rip_pkg::RADIX_RESET : rip_pkg::RADIX_HEX));

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    prefix_nxt    = prefix_r;
    act_radix_nxt = act_radix_r;
    do_start      = 1'b0;
    do_digits     = 1'b0;
    do_take       = 1'b0;

    unique case (phase_r)
      PH_WS: begin
        if (cls_item.is_space) begin
          phase_nxt = PH_WS;
        end else if (cls_item.is_minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_START;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_START:  do_start = 1'b1;
      PH_DIGITS: do_digits = 1'b1;
      PH_STOP:   phase_nxt = PH_STOP;
      default:   phase_nxt = PH_STOP;
    endcase

    if (do_start) begin
      if (zero_hex) begin
        acc_nxt    = '0;
        seen_nxt   = 1'b1;
        prefix_nxt = 1'b1;
        phase_nxt  = PH_DIGITS;
      end else begin
        do_take = 1'b1;
      end
    end

    if (do_digits) begin
      prefix_nxt = 1'b0;
      if (prefix_r && cls_item.is_x) begin
        acc_nxt  = '0;
        seen_nxt = 1'b0;
        if (radix_setting == rip_pkg::RADIX_AUTO) begin
          act_radix_nxt = rip_pkg::RADIX_HEX;
        end
      end else begin
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      if (RB'(cls_item.digit) >= radix) begin
        phase_nxt  = PH_STOP;
        prefix_nxt = 1'b0;
      end else begin
        acc_nxt   = mac;
        seen_nxt  = 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end
  end

  assign done_v_nxt = finish || (done_v_r && res_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WS;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      prefix_r    <= 1'b0;
      act_radix_r <= rip_pkg::RADIX_RESET;
      done_v_r    <= 1'b0;
    end else begin
      done_v_r <= done_v_nxt;
      if (finish) begin
        phase_r     <= PH_WS;
        acc_r       <= '0;
        neg_r       <= 1'b0;
        seen_r      <= 1'b0;
        prefix_r    <= 1'b0;
        act_radix_r <= rip_pkg::RADIX_RESET;
      end else if (fire) begin
        phase_r     <= phase_nxt;
        acc_r       <= acc_nxt;
        neg_r       <= neg_nxt;
        seen_r      <= seen_nxt;
        prefix_r    <= prefix_nxt;
        act_radix_r <= act_radix_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      fin_ok_r  <= seen_nxt && !bad;
      fin_acc_r <= (seen_nxt && !bad) ? acc_nxt : '0;
      fin_neg_r <= neg_nxt;
    end
  end

  assign res_push              = done_v_r;
  assign res_item.parsed_value = fin_neg_r ? signed'(-fin_acc_r) : signed'(fin_acc_r);
  assign res_item.is_defined   = fin_ok_r;

  `RIP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, finish, phase_r == PH_WS && !seen_r && !neg_r && acc_r == '0, "string state not cleared after last byte")
  `RIP_ASSERT_NEXT(a_done_hold, clk, rst_n, done_v_r && res_full, done_v_r && $stable(fin_acc_r), "pending result lost under stall")

endmodule
